FILE: rtl/vfcm_pkg.sv
// ----------------------------------------------------------------------------
// vfcm_pkg
// Shared types and constants of the voxel face culling mesher: field widths,
// action codes, register indexes and the job handed from scan to emit.
// ----------------------------------------------------------------------------
`default_nettype none

package vfcm_pkg;

  // Field widths of the stream items
  localparam int POS_X_W  = 4;
  localparam int POS_Y_W  = 6;
  localparam int POS_Z_W  = 4;
  localparam int KIND_W   = 2;
  localparam int ACT_W    = 2;
  localparam int OFF_W    = 16;
  localparam int WORLD_W  = 17;
  localparam int FACE_W   = 3;
  localparam int COUNT_W  = 17;
  localparam int BASE_W   = 19;
  localparam int NUM_FACE = 6;

  // Packed widths of the channels
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_IDX_W  = 2;

  // Input actions
  localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_EXAMINE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

  // Work handed from the scan sequencer to the emit stage
  typedef struct packed {
    logic                restart;
    logic [NUM_FACE-1:0] mask;
    logic [POS_X_W-1:0]  x;
    logic [POS_Y_W-1:0]  y;
    logic [POS_Z_W-1:0]  z;
  } job_t;

endpackage

`default_nettype wire

FILE: rtl/vfcm_ram.sv
// ----------------------------------------------------------------------------
// vfcm_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vfcm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vfcm_scan.sv
// ----------------------------------------------------------------------------
// vfcm_scan
// Voxel store sequencer: clears the store after reset, takes input transfers,
// writes voxels and walks the center and its six neighbors through the RAM
// read port, building the mask of visible faces.
// ----------------------------------------------------------------------------
`default_nettype none

module vfcm_scan
  import vfcm_pkg::*;
#(
  parameter int CHUNK_X   = 16,
  parameter int CHUNK_Y   = 64,
  parameter int CHUNK_Z   = 16,
  parameter int KIND_BITS = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic [ACT_W-1:0]     in_tuser,
  output job_t                      job,
  output logic                      job_valid,
  input  wire logic                 job_ready
);

  localparam int DEPTH  = CHUNK_X * CHUNK_Y * CHUNK_Z;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

  // Probe sequence: center, then faces +z, -z, -x, +x, +y, -y
  localparam logic [2:0] PROBE_CENTER = 3'd0;
  localparam logic [2:0] PROBE_PZ     = 3'd1;
  localparam logic [2:0] PROBE_NZ     = 3'd2;
  localparam logic [2:0] PROBE_NX     = 3'd3;
  localparam logic [2:0] PROBE_PX     = 3'd4;
  localparam logic [2:0] PROBE_PY     = 3'd5;
  localparam logic [2:0] PROBE_NY     = 3'd6;
  localparam logic [2:0] PROBE_DONE   = 3'd7;
  localparam logic [2:0] FIRST_FACE   = 3'd2;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_HOLD} state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic [2:0]          p_r, p_nxt;
  logic [POS_X_W-1:0]  x_r, x_nxt;
  logic [POS_Y_W-1:0]  y_r, y_nxt;
  logic [POS_Z_W-1:0]  z_r, z_nxt;
  logic [NUM_FACE-1:0] mask_r, mask_nxt;
  logic                restart_r, restart_nxt;
  logic                hit_r, hit_nxt;

  logic [ACT_W-1:0]     in_act;
  logic [POS_X_W-1:0]   in_x;
  logic [POS_Y_W-1:0]   in_y;
  logic [POS_Z_W-1:0]   in_z;
  logic [KIND_W-1:0]    in_kind;
  logic                 in_ok;
  logic [ADDR_W-1:0]    in_addr;

  logic signed [8:0]    nx, ny, nz;
  logic                 pok;
  logic [ADDR_W-1:0]    paddr;
  logic                 prev_solid;

  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [KIND_BITS-1:0] ram_wdata, ram_rdata;

  // Unpack the input transfer
  assign in_act  = in_tuser;
  assign in_x    = in_tdata[3:0];
  assign in_y    = in_tdata[9:4];
  assign in_z    = in_tdata[13:10];
  assign in_kind = in_tdata[15:14];

  assign in_ok   = (int'(in_x) < CHUNK_X) && (int'(in_y) < CHUNK_Y) &&
                   (int'(in_z) < CHUNK_Z);
  assign in_addr = ADDR_W'(int'(in_x) + CHUNK_X * (int'(in_z) + CHUNK_Z * int'(in_y)));

  // Neighbor coordinates and bounds for the current probe
  always_comb begin
    nx = $signed({5'd0, x_r});
    ny = $signed({3'd0, y_r});
    nz = $signed({5'd0, z_r});
    case (p_r)
      PROBE_PZ: nz = nz + 9'sd1;
      PROBE_NZ: nz = nz - 9'sd1;
      PROBE_NX: nx = nx - 9'sd1;
      PROBE_PX: nx = nx + 9'sd1;
      PROBE_PY: ny = ny + 9'sd1;
      PROBE_NY: ny = ny - 9'sd1;
      default: ;
    endcase
  end

  assign pok   = (nx >= 0) && (int'(nx) < CHUNK_X) && (ny >= 0) && (int'(ny) < CHUNK_Y) &&
                 (nz >= 0) && (int'(nz) < CHUNK_Z);
  assign paddr = ADDR_W'(int'(nx) + CHUNK_X * (int'(nz) + CHUNK_Z * int'(ny)));

  // Probe issued last cycle is solid only if it lay inside the chunk
  assign prev_solid = hit_r && (ram_rdata != '0);

  // Sequencer next state and RAM control
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    p_nxt       = p_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    z_nxt       = z_r;
    mask_nxt    = mask_r;
    restart_nxt = restart_r;
    hit_nxt     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = in_addr;
    ram_wdata   = KIND_BITS'(in_kind);
    ram_re      = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == ADDR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_act)
            ACT_WRITE: begin
              ram_we = in_ok;
            end
            ACT_EXAMINE: begin
              if (in_ok) begin
                x_nxt       = in_x;
                y_nxt       = in_y;
                z_nxt       = in_z;
                p_nxt       = PROBE_CENTER;
                mask_nxt    = '0;
                restart_nxt = 1'b0;
                state_nxt   = ST_SCAN;
              end
            end
            ACT_RESTART: begin
              restart_nxt = 1'b1;
              mask_nxt    = '0;
              state_nxt   = ST_HOLD;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // Issue one probe per cycle, consume the previous one
        if (p_r != PROBE_DONE) begin
          ram_re  = pok;
          hit_nxt = pok;
        end
        p_nxt = p_r + 3'd1;
        if (p_r == PROBE_PZ) begin
          if (!prev_solid) begin
            state_nxt = ST_IDLE;
          end
        end else if (p_r != PROBE_CENTER) begin
          mask_nxt[3'(p_r - FIRST_FACE)] = !prev_solid;
          if (p_r == PROBE_DONE) begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (job_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and registered sequencer values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      hit_r   <= hit_nxt;
    end
    p_r       <= p_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    z_r       <= z_nxt;
    mask_r    <= mask_nxt;
    restart_r <= restart_nxt;
  end

  vfcm_ram #(
    .WIDTH (KIND_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (paddr),
    .rdata (ram_rdata)
  );

  assign in_tready   = (state_r == ST_IDLE);
  assign job_valid   = (state_r == ST_HOLD);
  assign job.restart = restart_r;
  assign job.mask    = mask_r;
  assign job.x       = x_r;
  assign job.y       = y_r;
  assign job.z       = z_r;

endmodule

`default_nettype wire

FILE: rtl/vfcm_emit.sv
// ----------------------------------------------------------------------------
// vfcm_emit
// Face emitter: holds the chunk offsets and the face counter, and streams
// one result per visible face through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vfcm_emit
  import vfcm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [OFF_W-1:0]      cfg_wdata,
  input  wire job_t                  job,
  input  wire logic                  job_valid,
  output logic                       job_ready,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast
);

  logic [OFF_W-1:0]    off_x_r, off_y_r, off_z_r;
  logic [COUNT_W-1:0]  count_r;
  logic [NUM_FACE-1:0] mask_r;
  logic [POS_X_W-1:0]  x_r;
  logic [POS_Y_W-1:0]  y_r;
  logic [POS_Z_W-1:0]  z_r;
  logic                out_tvalid_r;
  logic [WORLD_W-1:0]  wx_r, wy_r, wz_r;
  logic [FACE_W-1:0]   face_r;
  logic [BASE_W-1:0]   base_r;
  logic                last_r;

  logic [FACE_W-1:0]   sel_face;
  logic [NUM_FACE-1:0] mask_rest;
  logic                take, load;

  // Pick the lowest pending face
  always_comb begin
    sel_face = '0;
    for (int f = NUM_FACE - 1; f >= 0; f--) begin
      if (mask_r[f]) begin
        sel_face = FACE_W'(f);
      end
    end
    mask_rest = mask_r & ~(NUM_FACE'(1) << sel_face);
  end

  assign job_ready = (mask_r == '0);
  assign take      = job_valid && job_ready;
  assign load      = (mask_r != '0) && (!out_tvalid_r || out_tready);

  // Offsets, counter, pending faces and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r      <= '0;
      off_y_r      <= '0;
      off_z_r      <= '0;
      count_r      <= '0;
      mask_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OFFSET_X: off_x_r <= cfg_wdata;
          REG_OFFSET_Y: off_y_r <= cfg_wdata;
          REG_OFFSET_Z: off_z_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (take) begin
        if (job.restart) begin
          count_r <= '0;
        end else begin
          mask_r <= job.mask;
        end
      end else if (load) begin
        mask_r  <= mask_rest;
        count_r <= count_r + 1'b1;
      end
      if (load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
    if (take && !job.restart) begin
      x_r <= job.x;
      y_r <= job.y;
      z_r <= job.z;
    end
    if (load) begin
      wx_r   <= WORLD_W'(x_r) + {off_x_r[OFF_W-1], off_x_r};
      wy_r   <= WORLD_W'(y_r) + {off_y_r[OFF_W-1], off_y_r};
      wz_r   <= WORLD_W'(z_r) + {off_z_r[OFF_W-1], off_z_r};
      face_r <= sel_face;
      base_r <= {count_r, 2'b00};
      last_r <= (mask_rest == '0);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {7'd0, base_r, face_r, wz_r, wy_r, wx_r};

endmodule

`default_nettype wire

FILE: rtl/voxel_face_cull_mesher.sv
// ----------------------------------------------------------------------------
// voxel_face_cull_mesher
// Chunk voxel store with face culling: writes voxels, examines a voxel and
// streams one result per face that borders air or the chunk boundary.
// ----------------------------------------------------------------------------
// After reset the block sweeps the voxel RAM to air, one entry per cycle;
// in_tready stays low meanwhile, configuration writes are taken at any time.
// A write, an unused action or an examine outside the chunk leaves the block
// idle; a restart passes through hand-off. An examine of a solid voxel reads
// the voxel and then each of its six neighbors through the single RAM read
// port, pipelined against the registered read data, via accept and hand-off;
// an examine of air returns to idle once the center read shows air. A restart
// or a solid examine waits in hand-off for as long as the emitter still holds
// faces of the previous voxel, so stalls on out_tready hold back the input.
// The faces of one voxel leave at one per cycle while out_tready is high,
// from a registered output stage as the next items are taken.
`default_nettype none

module voxel_face_cull_mesher
  import vfcm_pkg::*;
#(
  parameter int CHUNK_X   = 16,
  parameter int CHUNK_Y   = 64,
  parameter int CHUNK_Z   = 16,
  parameter int KIND_BITS = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [OFF_W-1:0]      cfg_wdata,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // block_x, block_y, block_z, block_kind
  input  wire logic [ACT_W-1:0]      in_tuser,   // action
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // world_x, world_y, world_z, face_dir,
                                                 // vertex_base, zero fill
  output logic                       out_tlast   // last_face
);

  job_t job;
  logic job_valid;
  logic job_ready;

  vfcm_scan #(
    .CHUNK_X   (CHUNK_X),
    .CHUNK_Y   (CHUNK_Y),
    .CHUNK_Z   (CHUNK_Z),
    .KIND_BITS (KIND_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready)
  );

  vfcm_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .job        (job),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
